// File: src/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg: shared types and codes for the timeout aging table
// Field widths, operation codes, result status codes and controller states.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int MODE_W   = 2;
    localparam int TAG_W    = 64;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;

    // Operation codes carried on the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_SWEEP  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_HIT      = 3'd2,
        STAT_MISS     = 3'd3,
        STAT_EXPIRED  = 3'd4,
        STAT_DONE     = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

// File: src/tat_cell.sv
// ----------------------------------------------------------------------------
// tat_cell: one table entry in the rotating ring
// Holds valid mark, key and last-used stamp; loads the neighbor's entry on
// every shift so the whole table rotates past the head of the ring.
// ----------------------------------------------------------------------------
module tat_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_valid,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [tat_pkg::TIME_W-1:0]  i_stamp,
    output logic                        o_valid,
    output logic [KEY_BITS-1:0]         o_key,
    output logic [tat_pkg::TIME_W-1:0]  o_stamp
);
    import tat_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [TIME_W-1:0]   r_stamp;

    // Valid mark: cleared at reset, table starts empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // Key and stamp: read only while valid, no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_key;
            r_stamp <= i_stamp;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_stamp = r_stamp;

endmodule

// File: src/timeout_aging_table.sv
// ----------------------------------------------------------------------------
// timeout_aging_table: keyed entry table with last-used stamps and aging
// Insert, touch and sweep operations over a ring of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one command: mode, key, now.
//   Output channel (o_valid/i_ready) returns results; o_last marks the final
//   result of a command. Insert and touch give one result; a sweep gives one
//   result per freed entry, then a done result. Mode 3 is taken and dropped.
//   The expiry timeout is written through i_cfg_we/i_cfg_wdata; the user must
//   do so only while idle, as the block leaves that check to the user.
// Ring:
//   The entries sit in a ring of TABLE_ENTRIES cells that rotates one step a
//   cycle while a command runs, unless a stall holds it; each command takes
//   one full rotation past the head cell. An insert or touch result is loaded
//   once the rotation ends.
// Stalls:
//   A single output register holds the pending result. When it is full and
//   not taken, the ring stops on an expiring entry until the result leaves.
// Reset:
//   Synchronous, active low: table empty, timeout 60, no result pending.
// ----------------------------------------------------------------------------
module timeout_aging_table #(
    parameter int TABLE_ENTRIES = 32,
    parameter int KEY_BITS      = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [tat_pkg::TIME_W-1:0]    i_cfg_wdata,
    // command channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tat_pkg::MODE_W-1:0]    i_mode,
    input  logic [tat_pkg::TAG_W-1:0]     i_key,
    input  logic [tat_pkg::TIME_W-1:0]    i_now,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tat_pkg::STATUS_W-1:0]  o_status,
    output logic [tat_pkg::SLOT_W-1:0]    o_slot,
    output logic [tat_pkg::TAG_W-1:0]     o_entry_tag,
    output logic                          o_last
);
    import tat_pkg::*;

    localparam int STEP_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_ENTRIES - 1);

    // Ring of cells
    logic                c_valid [TABLE_ENTRIES];
    logic [KEY_BITS-1:0] c_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]   c_stamp [TABLE_ENTRIES];

    logic                h_next_valid;
    logic [KEY_BITS-1:0] h_next_key;
    logic [TIME_W-1:0]   h_next_stamp;
    logic                shift;

    // Control registers
    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_timeout;
    logic [STEP_W-1:0]   r_step;
    logic                r_found;
    logic [SLOT_W-1:0]   r_found_slot;

    // Output register
    logic                r_ov;
    t_status             r_o_status;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [TAG_W-1:0]    r_o_tag;
    logic                r_o_last;

    logic                take;
    logic                expire;
    logic                out_free;
    logic                emit_step;
    logic                emit_final;
    logic                cmd_xfer;
    logic [TIME_W-1:0]   age;
    t_status             res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [TAG_W-1:0]    res_tag;
    logic                res_last;

    // Build the ring: each cell loads its upper neighbor, the top cell
    // loads the (possibly updated) head entry
    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        if (gi == TABLE_ENTRIES - 1) begin : g_top
            tat_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_valid (h_next_valid),
                .i_key   (h_next_key),
                .i_stamp (h_next_stamp),
                .o_valid (c_valid[gi]),
                .o_key   (c_key[gi]),
                .o_stamp (c_stamp[gi])
            );
        end else begin : g_mid
            tat_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_valid (c_valid[gi+1]),
                .i_key   (c_key[gi+1]),
                .i_stamp (c_stamp[gi+1]),
                .o_valid (c_valid[gi]),
                .o_key   (c_key[gi]),
                .o_stamp (c_stamp[gi])
            );
        end
    end

    assign cmd_xfer = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign age      = r_now - c_stamp[0];

    // Evaluate the head entry for the current command
    always_comb begin
        take         = 1'b0;
        expire       = 1'b0;
        h_next_valid = c_valid[0];
        h_next_key   = c_key[0];
        h_next_stamp = c_stamp[0];
        case (r_mode)
            MODE_INSERT: take   = !r_found && !c_valid[0];
            MODE_TOUCH:  take   = !r_found && c_valid[0] && (c_key[0] == r_key);
            MODE_SWEEP:  expire = c_valid[0] && (age > r_timeout);
            default:     ;
        endcase
        if (take) begin
            h_next_valid = 1'b1;
            h_next_key   = r_key;
            h_next_stamp = r_now;
        end
        if (expire) begin
            h_next_valid = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_xfer && (t_mode'(i_mode) != MODE_NONE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (shift && (r_step == LAST_STEP)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready    = 1'b0;
        shift      = 1'b0;
        emit_step  = 1'b0;
        emit_final = 1'b0;
        unique case (r_state)
            S_IDLE:   o_ready    = 1'b1;
            S_SCAN: begin
                shift     = !expire || out_free;
                emit_step = expire && out_free;
            end
            S_FINISH: emit_final = out_free;
            default:  ;
        endcase
    end

    // Select the result to load
    always_comb begin
        res_status = STAT_DONE;
        res_slot   = '0;
        res_tag    = '0;
        res_last   = 1'b1;
        if (emit_step) begin
            res_status = STAT_EXPIRED;
            res_slot   = SLOT_W'(r_step);
            res_tag    = TAG_W'(c_key[0]);
            res_last   = 1'b0;
        end else begin
            case (r_mode)
                MODE_INSERT: begin
                    res_status = r_found ? STAT_INSERTED : STAT_FULL;
                    res_slot   = r_found ? r_found_slot : '0;
                    res_tag    = r_found ? TAG_W'(r_key) : '0;
                end
                MODE_TOUCH: begin
                    res_status = r_found ? STAT_HIT : STAT_MISS;
                    res_slot   = r_found ? r_found_slot : '0;
                    res_tag    = r_found ? TAG_W'(r_key) : '0;
                end
                default: res_status = STAT_DONE;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIME_W'(60);
            r_found   <= 1'b0;
            r_step    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (cmd_xfer) begin
                r_found <= 1'b0;
                r_step  <= '0;
            end else if (shift) begin
                r_step <= r_step + 1'b1;
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (emit_step || emit_final) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Command payload and found slot
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_key[KEY_BITS-1:0];
            r_now  <= i_now;
        end
        if (shift && take) begin
            r_found_slot <= SLOT_W'(r_step);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit_step || emit_final) begin
            r_o_status <= res_status;
            r_o_slot   <= res_slot;
            r_o_tag    <= res_tag;
            r_o_last   <= res_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_status    = r_o_status;
    assign o_slot      = r_o_slot;
    assign o_entry_tag = r_o_tag;
    assign o_last      = r_o_last;

endmodule

// File: src/tat_checker.sv
// ----------------------------------------------------------------------------
// tat_checker: port-level checks for the timeout aging table
// Watches the command and result channels of the top level over time.
// ----------------------------------------------------------------------------
module tat_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [tat_pkg::MODE_W-1:0]    i_mode,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [tat_pkg::STATUS_W-1:0]  o_status,
    input logic [tat_pkg::SLOT_W-1:0]    o_slot,
    input logic [tat_pkg::TAG_W-1:0]     o_entry_tag,
    input logic                          o_last
);
    import tat_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_entry_tag) && $stable(o_last))
        else $error("stalled result changed");

    // A real command blocks the next transfer while it runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode != MODE_NONE) |=> !o_ready)
        else $error("command taken while busy");

    // Only expiry results are non-final
    a_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == STAT_EXPIRED)
        else $error("non-final result is not an expiry");

    // No-slot results carry zero slot and tag
    a_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_DONE || o_status == STAT_FULL
            || o_status == STAT_MISS) |-> o_slot == '0 && o_entry_tag == '0 && o_last)
        else $error("no-slot result carries a slot or tag");

endmodule

bind timeout_aging_table tat_checker u_tat_checker (.*);

// File: tb/sv/timeout_aging_table_tb.sv
// ----------------------------------------------------------------------------
// timeout_aging_table_tb: self-checking bench for the timeout aging table
// Drives insert, touch and sweep commands over the command channel, predicts
// every result with a shadow copy of the table and compares each result
// transfer field by field. A short directed table comes first, then random
// phases under several expiry timeouts, with idle gaps and a long result stall.
// ----------------------------------------------------------------------------
module timeout_aging_table_tb;
    import tat_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int KEY_BITS      = 64;
    localparam logic [TAG_W-1:0] KEY_MASK = {TAG_W{1'b1}} >> (TAG_W - KEY_BITS);
    localparam int PHASES        = 5;
    localparam int PHASE_CMDS    = 78;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic               last;
    } t_table_result;

    typedef struct packed {
        t_mode              mode;
        logic [TAG_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic               typed;
        t_table_result      want;
    } t_cmd_row;

    localparam t_table_result NO_TYPED = '{STAT_INSERTED, 5'd0, 64'd0, 1'b0};
    localparam int DIRECTED_ROWS = 20;

    // Directed commands, timeout at its reset value of 60
    t_cmd_row directed_cmds [DIRECTED_ROWS] = '{
        '{MODE_SWEEP,  64'h0, 32'h0, 1'b1, '{STAT_DONE, 5'd0, 64'h0, 1'b1}},
        '{MODE_TOUCH,  64'h0, 32'h0, 1'b1, '{STAT_MISS, 5'd0, 64'h0, 1'b1}},
        '{MODE_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_TYPED},
        '{MODE_INSERT, 64'h0, 32'h0, 1'b1, '{STAT_INSERTED, 5'd0, 64'h0, 1'b1}},
        '{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{STAT_INSERTED, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
        '{MODE_INSERT, 64'h0, 32'd100, 1'b1, '{STAT_INSERTED, 5'd2, 64'h0, 1'b1}},
        '{MODE_TOUCH,  64'h0, 32'd10, 1'b0, NO_TYPED},
        '{MODE_TOUCH,  64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 1'b0, NO_TYPED},
        '{MODE_TOUCH,  64'h1, 32'd5, 1'b1, '{STAT_MISS, 5'd0, 64'h0, 1'b1}},
        '{MODE_SWEEP,  64'h0, 32'd70, 1'b0, NO_TYPED},
        '{MODE_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, 32'd70, 1'b0, NO_TYPED},
        '{MODE_TOUCH,  64'h0, 32'hFFFF_FFFF, 1'b0, NO_TYPED},
        '{MODE_SWEEP,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0, NO_TYPED},
        '{MODE_SWEEP,  64'h0, 32'd60, 1'b0, NO_TYPED},
        '{MODE_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'h7FFF_FFFF, 1'b0, NO_TYPED},
        '{MODE_SWEEP,  64'h0, 32'h8000_003B, 1'b0, NO_TYPED},
        '{MODE_SWEEP,  64'h0, 32'h8000_003C, 1'b0, NO_TYPED},
        '{MODE_NONE,   64'h0, 32'h0, 1'b0, NO_TYPED},
        '{MODE_INSERT, 64'h0123_4567_89AB_CDEF, 32'h1234_5678, 1'b0, NO_TYPED},
        '{MODE_TOUCH,  64'h0123_4567_89AB_CDEF, 32'hFEDC_BA98, 1'b0, NO_TYPED}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [TIME_W-1:0]    i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [MODE_W-1:0]    i_mode      = '0;
    logic [TAG_W-1:0]     i_key       = '0;
    logic [TIME_W-1:0]    i_now       = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic [TAG_W-1:0]     o_entry_tag;
    logic                 o_last;

    // Shadow table and timeout
    logic                 shadow_valid [TABLE_ENTRIES];
    logic [TAG_W-1:0]     shadow_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]    shadow_stamp [TABLE_ENTRIES];
    logic [TIME_W-1:0]    shadow_timeout = 32'd60;

    t_table_result        pending_results [$];
    t_table_result        seen_result;
    int                   mismatch_cnt = 0;
    bit                   idle_on      = 1'b1;
    bit                   hold_req     = 1'b0;
    int                   hold_left    = 0;

    timeout_aging_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_now       (i_now),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_entry_tag (o_entry_tag),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the shadow table and collect the results it causes
    function automatic void table_apply(input t_mode m, input logic [TAG_W-1:0] k_in,
                                        input logic [TIME_W-1:0] t,
                                        ref t_table_result res [$]);
        int                slot_hit;
        logic [TAG_W-1:0]  k;
        logic [TIME_W-1:0] age;
        res.delete();
        slot_hit = -1;
        k = k_in & KEY_MASK;
        case (m)
            MODE_INSERT: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!shadow_valid[i] && slot_hit < 0) slot_hit = i;
                if (slot_hit >= 0) begin
                    shadow_valid[slot_hit] = 1'b1;
                    shadow_key[slot_hit]   = k;
                    shadow_stamp[slot_hit] = t;
                    res.push_back('{STAT_INSERTED, SLOT_W'(slot_hit), k, 1'b1});
                end else begin
                    res.push_back('{STAT_FULL, 5'd0, 64'd0, 1'b1});
                end
            end
            MODE_TOUCH: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (slot_hit < 0 && shadow_valid[i] && shadow_key[i] == k) slot_hit = i;
                if (slot_hit >= 0) begin
                    shadow_stamp[slot_hit] = t;
                    res.push_back('{STAT_HIT, SLOT_W'(slot_hit), k, 1'b1});
                end else begin
                    res.push_back('{STAT_MISS, 5'd0, 64'd0, 1'b1});
                end
            end
            MODE_SWEEP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    age = t - shadow_stamp[i];
                    if (shadow_valid[i] && age > shadow_timeout) begin
                        shadow_valid[i] = 1'b0;
                        res.push_back('{STAT_EXPIRED, SLOT_W'(i), shadow_key[i], 1'b0});
                    end
                end
                res.push_back('{STAT_DONE, 5'd0, 64'd0, 1'b1});
            end
            default: ;
        endcase
    endfunction

    // Offer one command, wait for its transfer, then record what it must return
    task automatic offer_cmd(input t_mode m, input logic [TAG_W-1:0] k,
                             input logic [TIME_W-1:0] t, input logic typed,
                             input t_table_result want);
        int            gap;
        t_table_result res [$];
        gap = 0;
        if (idle_on) begin
            if ($urandom_range(99) < 10) gap = $urandom_range(40, 1);
            else while ($urandom_range(99) < 32) gap++;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= m;
        i_key   <= k;
        i_now   <= t;
        do @(posedge i_clk); while (!o_ready);
        table_apply(m, k, t, res);
        if (typed) pending_results.push_back(want);
        else foreach (res[j]) pending_results.push_back(res[j]);
    endtask

    // Drain the expected results, let the block go idle, then write the timeout
    task automatic set_timeout(input logic [TIME_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_timeout = value;
    endtask

    task automatic report_mismatch(input string what, input t_table_result want,
                                   input t_table_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
            $write("%0t: %s: expected status %0d slot %0d tag %h last %0b,",
                   $realtime, what, want.status, want.slot, want.tag, want.last);
            $display(" got status %0d slot %0d tag %h last %0b",
                     got.status, got.slot, got.tag, got.last);
        end
    endtask

    // Result side: random stalls while idle gaps are on, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (idle_on) begin
                i_ready <= ($urandom_range(99) >= 32);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result = '{t_status'(o_status), o_slot, o_entry_tag, o_last};
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", NO_TYPED, seen_result);
            else if (seen_result !== pending_results[0])
                report_mismatch("result mismatch", pending_results.pop_front(), seen_result);
            else
                void'(pending_results.pop_front());
        end
    end

    initial begin
        logic [TIME_W-1:0] phase_timeout [PHASES];
        logic [TAG_W-1:0]  key_pool [$];
        logic [TAG_W-1:0]  key;
        logic [TIME_W-1:0] wall;
        t_mode             mode;
        int                pick;

        foreach (shadow_valid[i]) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_stamp[i] = '0;
        end
        phase_timeout = '{32'hFFFF_FFFF, 32'd0, 32'd20, 32'($urandom_range(200, 1)),
                          32'($urandom)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_cmds[r])
            offer_cmd(directed_cmds[r].mode, directed_cmds[r].key, directed_cmds[r].now,
                      directed_cmds[r].typed, directed_cmds[r].want);

        // Random phases: full table first, then everything expiring at once, then other timeouts
        wall = 32'd1000;
        for (int p = 0; p < PHASES; p++) begin
            set_timeout(phase_timeout[p]);
            idle_on = (p != 2);
            if (p == 1) hold_req = 1'b1;
            if ($urandom_range(3) == 0) wall = 32'hFFFF_FF00 + 32'($urandom_range(255));
            for (int n = 0; n < PHASE_CMDS; n++) begin
                // Advance the clock, now and then jump or step back
                pick = $urandom_range(99);
                if (pick < 4) wall = $urandom;
                else if (pick < 8) wall -= 32'($urandom_range(100));
                else wall += 32'($urandom_range(15));
                key  = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 55) begin
                    mode = MODE_INSERT;
                    if (key_pool.size() != 0 && $urandom_range(3) == 0) begin
                        key = key_pool[$urandom_range(key_pool.size() - 1)];
                    end else begin
                        key_pool.push_back(key);
                        if (key_pool.size() > 8) void'(key_pool.pop_front());
                    end
                end else if (pick < 80) begin
                    mode = MODE_TOUCH;
                    if (key_pool.size() != 0 && $urandom_range(3) != 0)
                        key = key_pool[$urandom_range(key_pool.size() - 1)];
                end else if (pick < 95) begin
                    mode = MODE_SWEEP;
                end else begin
                    mode = MODE_NONE;
                end
                offer_cmd(mode, key, wall, 1'b0, NO_TYPED);
            end
        end

        // Drain and let the block settle
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("timeout_aging_table regression: pass");
        else
            $display("timeout_aging_table regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("timeout_aging_table regression: fail");
        $finish;
    end

endmodule
